// File: hw/rtl/htbd_pkg.sv
// shared types and constants for the huffman tree bit decoder
// no dependencies
package htbd_pkg;

	localparam int NODE_COUNT_DEF  = 511;
	localparam int STACK_DEPTH_DEF = 256;
	localparam int SYM_W           = 8;
	localparam int IDX_W           = 9;
	localparam int LVL_W           = 9;
	localparam int CFG_W           = 32;
	localparam int SEEN_W          = 4;
	localparam logic [CFG_W-1:0] BLOCK_SIZE_RST = 32'd4096;

	typedef enum logic {
		OP_TREE = 1'b0,
		OP_DATA = 1'b1
	} op_t;

	typedef enum logic {
		REG_BLOCK_SIZE   = 1'b0,
		REG_SYMBOL_COUNT = 1'b1
	} cfg_reg_t;

	// leaf flag and symbol of one node
	typedef struct packed {
		logic             leaf;
		logic [SYM_W-1:0] sym;
	} node_kind_t;

	typedef struct packed {
		logic             kind_we;
		logic [IDX_W-1:0] kind_addr;
		node_kind_t       kind_data;
		logic             right_we;
		logic [IDX_W-1:0] right_addr;
		logic [IDX_W-1:0] right_data;
	} node_wr_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} node_rd_t;

	typedef struct packed {
		node_kind_t       kind;
		logic [IDX_W-1:0] right;
	} node_ent_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             last;
	} result_t;

endpackage

// File: hw/rtl/huffman_tree_bit_decoder.sv
// top level of the huffman tree bit decoder
// depends on htbd_pkg, htbd_node_mem, htbd_builder, htbd_walker, htbd_out_queue
//
// input channel: in_valid/in_stall with op and bit_req, one bit per beat.
//   op=0 beats carry the preorder code tree, op=1 beats carry coded bits.
// output channel: out_valid/out_stall with symbol and last.
// config: cfg_we/cfg_idx/cfg_wdata, block_size and symbol_count, write while idle.
// throughput: one input beat per cycle while in_stall is low; the walk reads one node per coded bit
//   and that read's child field addresses the next read, with the current
//   node entry held in a register and the root entry kept in flip-flops.
// a beat is registered in the input register and processed once the result
//   queue has room; its symbol is written into that queue, which drives the output.
// a leaf symbol comes out on the coded bit that follows the leaf.
// reset clears all control state; the tree must be sent again after reset.
// node and stack memories need no clearing pass.
// when the receiver stalls, up to two results wait in a queue and one more
//   beat waits in the input register before in_stall rises.
module huffman_tree_bit_decoder #(
	parameter int NODE_COUNT  = htbd_pkg::NODE_COUNT_DEF,
	parameter int STACK_DEPTH = htbd_pkg::STACK_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       op,
	input  logic                       bit_req,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [htbd_pkg::SYM_W-1:0] symbol,
	output logic                       last,
	input  logic                       cfg_we,
	input  logic                       cfg_idx,
	input  logic [htbd_pkg::CFG_W-1:0] cfg_wdata
);
	import htbd_pkg::*;

	logic             v_s1, op_s1, bit_s1;
	logic             adv, full;
	logic [CFG_W-1:0] block_size_q, symbol_count_q;
	node_wr_t         wr;
	node_rd_t         rd;
	node_ent_t        rd_data, root;
	logic [IDX_W-1:0] nodes_used;
	logic             complete;
	logic             res_valid;
	result_t          res, out_data;

	assign adv      = v_s1 && !full;
	assign in_stall = v_s1 && full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1  <= op;
			bit_s1 <= bit_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q   <= BLOCK_SIZE_RST;
			symbol_count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_BLOCK_SIZE:   block_size_q   <= cfg_wdata;
				REG_SYMBOL_COUNT: symbol_count_q <= cfg_wdata;
			endcase
		end
	end

	htbd_node_mem #(.NODE_COUNT(NODE_COUNT)) u_mem (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	htbd_builder #(.NODE_COUNT(NODE_COUNT), .STACK_DEPTH(STACK_DEPTH)) u_build (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv && op_s1 == OP_TREE),
		.bit_in     (bit_s1),
		.wr         (wr),
		.root       (root),
		.nodes_used (nodes_used),
		.complete   (complete)
	);

	htbd_walker u_walk (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (adv && op_s1 == OP_DATA),
		.bit_in       (bit_s1),
		.block_size   (block_size_q),
		.symbol_count (symbol_count_q),
		.complete     (complete),
		.nodes_used   (nodes_used),
		.root         (root),
		.rd_data      (rd_data),
		.rd           (rd),
		.res_valid    (res_valid),
		.res          (res)
	);

	htbd_out_queue u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign symbol = out_data.symbol;
	assign last   = out_data.last;

endmodule

// File: hw/rtl/htbd_node_mem.sv
// node store: kind/symbol and right-child memories, registered read
// depends on htbd_pkg
module htbd_node_mem #(
	parameter int NODE_COUNT = htbd_pkg::NODE_COUNT_DEF
) (
	input  logic               clk,
	input  htbd_pkg::node_wr_t wr,
	input  htbd_pkg::node_rd_t rd,
	output htbd_pkg::node_ent_t rd_data
);
	import htbd_pkg::*;

	localparam int NAW = $clog2(NODE_COUNT);

	node_kind_t       kind_mem [NODE_COUNT];
	logic [IDX_W-1:0] right_mem [NODE_COUNT];

	always_ff @(posedge clk) begin
		if (wr.kind_we) begin
			kind_mem[wr.kind_addr[NAW-1:0]] <= wr.kind_data;
		end
		if (wr.right_we) begin
			right_mem[wr.right_addr[NAW-1:0]] <= wr.right_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data.kind  <= kind_mem[rd.addr[NAW-1:0]];
			rd_data.right <= right_mem[rd.addr[NAW-1:0]];
		end
	end

endmodule

// File: hw/rtl/htbd_builder.sv
// tree builder: takes preorder tree bits, writes the node store, keeps the slot stack
// depends on htbd_pkg
module htbd_builder #(
	parameter int NODE_COUNT  = htbd_pkg::NODE_COUNT_DEF,
	parameter int STACK_DEPTH = htbd_pkg::STACK_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic                     bit_in,
	output htbd_pkg::node_wr_t       wr,
	output htbd_pkg::node_ent_t      root,
	output logic [htbd_pkg::IDX_W-1:0] nodes_used,
	output logic                     complete
);
	import htbd_pkg::*;

	localparam int SDEP = STACK_DEPTH - 1;
	localparam int SAW  = (SDEP > 1) ? $clog2(SDEP) : 1;

	logic [IDX_W-1:0]  nodes_q, nodes_d;
	logic [LVL_W-1:0]  level_q, level_d;
	logic [IDX_W-1:0]  pend_node_q, pend_node_d;
	logic              pend_right_q, pend_right_d;
	logic              pend_root_q, pend_root_d;
	logic [SYM_W-1:0]  shift_q, shift_d;
	logic [SEEN_W-1:0] seen_q, seen_d;
	logic              complete_q, complete_d;
	logic [IDX_W-1:0]  tos_q, tos_d;
	logic [IDX_W-1:0]  stk_rd_q;
	node_ent_t         root_q, root_d;
	logic              push;
	logic [IDX_W-1:0]  stk_mem [SDEP];
	logic [SYM_W-1:0]  shift_nx;
	logic              room;
	logic              link_right;
	logic [LVL_W-1:0]  lvl_m1, lvl_m2;

	assign room     = nodes_q < IDX_W'(NODE_COUNT);
	assign shift_nx = {shift_q[SYM_W-2:0], bit_in};
	assign link_right = !pend_root_q && pend_right_q;
	assign lvl_m1   = level_q - LVL_W'(1);
	assign lvl_m2   = level_q - LVL_W'(2);

	always_comb begin
		nodes_d      = nodes_q;
		level_d      = level_q;
		pend_node_d  = pend_node_q;
		pend_right_d = pend_right_q;
		pend_root_d  = pend_root_q;
		shift_d      = shift_q;
		seen_d       = seen_q;
		complete_d   = complete_q;
		tos_d        = tos_q;
		root_d       = root_q;
		push         = 1'b0;
		wr           = '0;
		wr.kind_addr = nodes_q;
		if (step && !complete_q) begin
			priority if (seen_q != '0) begin
				shift_d = shift_nx;
				seen_d  = seen_q + SEEN_W'(1);
				if (seen_q == SEEN_W'(SYM_W)) begin
					if (room) begin
						wr.kind_we   = 1'b1;
						wr.kind_data = '{leaf: 1'b1, sym: shift_nx};
						if (link_right) begin
							wr.right_we   = 1'b1;
							wr.right_addr = pend_node_q;
							wr.right_data = nodes_q;
							if (pend_node_q == '0) root_d.right = nodes_q;
						end
						if (nodes_q == '0) root_d.kind = '{leaf: 1'b1, sym: shift_nx};
						nodes_d = nodes_q + IDX_W'(1);
					end
					seen_d  = '0;
					shift_d = '0;
					// node finished: pop the next open right slot
					if (level_q == '0) begin
						complete_d = 1'b1;
					end else begin
						level_d      = lvl_m1;
						pend_node_d  = tos_q;
						pend_right_d = 1'b1;
						pend_root_d  = 1'b0;
						tos_d        = stk_rd_q;
					end
				end
			end else if (bit_in) begin
				if (room) begin
					seen_d  = SEEN_W'(1);
					shift_d = '0;
				end
			end else begin
				if (room && level_q < LVL_W'(STACK_DEPTH)) begin
					wr.kind_we   = 1'b1;
					wr.kind_data = '0;
					wr.right_we  = 1'b1;
					if (link_right) begin
						wr.right_addr = pend_node_q;
						wr.right_data = nodes_q;
						if (pend_node_q == '0) root_d.right = nodes_q;
					end else begin
						wr.right_addr = nodes_q;
						wr.right_data = '0;
					end
					if (nodes_q == '0) root_d = '0;
					nodes_d      = nodes_q + IDX_W'(1);
					push         = 1'b1;
					tos_d        = nodes_q;
					level_d      = level_q + LVL_W'(1);
					pend_node_d  = nodes_q;
					pend_right_d = 1'b0;
					pend_root_d  = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodes_q      <= '0;
			level_q      <= '0;
			pend_node_q  <= '0;
			pend_right_q <= 1'b0;
			pend_root_q  <= 1'b1;
			shift_q      <= '0;
			seen_q       <= '0;
			complete_q   <= 1'b0;
			tos_q        <= '0;
			root_q       <= '0;
		end else begin
			nodes_q      <= nodes_d;
			level_q      <= level_d;
			pend_node_q  <= pend_node_d;
			pend_right_q <= pend_right_d;
			pend_root_q  <= pend_root_d;
			shift_q      <= shift_d;
			seen_q       <= seen_d;
			complete_q   <= complete_d;
			tos_q        <= tos_d;
			root_q       <= root_d;
		end
	end

	// entries below top of stack; read is prefetched every cycle
	always_ff @(posedge clk) begin
		if (push && level_q != '0) begin
			stk_mem[lvl_m1[SAW-1:0]] <= tos_q;
		end
		stk_rd_q <= stk_mem[lvl_m2[SAW-1:0]];
	end

	assign root       = root_q;
	assign nodes_used = nodes_q;
	assign complete   = complete_q;

endmodule

// File: hw/rtl/htbd_walker.sv
// tree walker: one coded bit per beat, one node read per bit
// depends on htbd_pkg
module htbd_walker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic                        bit_in,
	input  logic [htbd_pkg::CFG_W-1:0]  block_size,
	input  logic [htbd_pkg::CFG_W-1:0]  symbol_count,
	input  logic                        complete,
	input  logic [htbd_pkg::IDX_W-1:0]  nodes_used,
	input  htbd_pkg::node_ent_t         root,
	input  htbd_pkg::node_ent_t         rd_data,
	output htbd_pkg::node_rd_t          rd,
	output logic                        res_valid,
	output htbd_pkg::result_t           res
);
	import htbd_pkg::*;

	logic [IDX_W-1:0] cur_q;
	logic             at_root_q;
	logic [CFG_W-1:0] pos_q;
	logic [CFG_W-1:0] emitted_q;
	node_ent_t        cur_ent, ent2;
	logic             go;
	logic             go_root;
	logic [IDX_W-1:0] node, left, next;
	logic [IDX_W:0]   node_p1;
	logic [CFG_W-1:0] bs;
	logic [CFG_W:0]   pos_p1;
	logic [CFG_W-1:0] emitted_p1;

	assign go      = step && complete && (emitted_q < symbol_count);
	assign cur_ent = at_root_q ? root : rd_data;
	assign go_root = cur_ent.kind.leaf || (pos_q == '0);
	assign node    = go_root ? '0 : cur_q;
	assign ent2    = go_root ? root : cur_ent;
	assign node_p1 = {1'b0, node} + (IDX_W+1)'(1);
	// left child is always the next node built, if it exists
	assign left    = (node_p1 < {1'b0, nodes_used}) ? node_p1[IDX_W-1:0] : '0;
	assign next    = ent2.kind.leaf ? node : (bit_in ? ent2.right : left);
	assign bs      = (block_size == '0) ? CFG_W'(1) : block_size;
	assign pos_p1  = {1'b0, pos_q} + (CFG_W+1)'(1);
	assign emitted_p1 = emitted_q + CFG_W'(1);

	assign rd.en      = go;
	assign rd.addr    = next;
	assign res_valid  = go && cur_ent.kind.leaf;
	assign res.symbol = cur_ent.kind.sym;
	assign res.last   = emitted_p1 == symbol_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= '0;
			at_root_q <= 1'b1;
			pos_q     <= '0;
			emitted_q <= '0;
		end else if (go) begin
			cur_q     <= next;
			at_root_q <= next == '0;
			pos_q     <= (pos_p1 >= {1'b0, bs}) ? '0 : pos_p1[CFG_W-1:0];
			if (cur_ent.kind.leaf) emitted_q <= emitted_p1;
		end
	end

endmodule

// File: hw/rtl/htbd_out_queue.sv
// two-entry result queue in front of the output channel
// depends on htbd_pkg
module htbd_out_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  htbd_pkg::result_t push_data,
	output logic              full,
	output logic              out_valid,
	input  logic              out_stall,
	output htbd_pkg::result_t out_data
);
	import htbd_pkg::*;

	result_t    mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop       = out_valid && !out_stall;
	assign full      = cnt_q == 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_data  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// File: hw/rtl/htbd_checker.sv
// port-level checks for the huffman tree bit decoder, bound to the top level
// depends on huffman_tree_bit_decoder
module htbd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] symbol,
	input logic       last
);

	// a stalled result beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped under stall");

	// input only backs up when results are waiting
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no pending result");

	// one taken result frees room for the waiting beat
	a_stall_release: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && !out_stall |=> !in_stall)
		else $error("input still stalled after a result was taken");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(symbol) && $stable(last))
		else $error("stalled result changed");

endmodule

bind huffman_tree_bit_decoder htbd_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.symbol    (symbol),
	.last      (last)
);
